// ----- design/cbrt_pkg.sv -----
// Shared types and constants for the integer cube root pipeline.
// Used by cbrt_cell and integer_cube_root; depends on nothing else.
package cbrt_pkg;

  localparam int INPUT_WIDTH = 64;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 22;
  localparam int NUM_CELLS   = 22;
  // Radicand padded at the top so that it splits into whole 3-bit groups.
  localparam int BITS_W      = 3 * NUM_CELLS;
  localparam int SQ_W        = 2 * ROOT_W;
  localparam int REM_W       = 48;
  localparam int TRIAL_W     = REM_W + 3;
  localparam int OUT_TDATA_W = 24;

  localparam logic [RAD_W-1:0] RAD_MASK = {RAD_W{1'b1}} >> (RAD_W - INPUT_WIDTH);

  // Partial result handed from one cell to the next.
  typedef struct packed {
    logic [REM_W-1:0]  rem;   // running remainder
    logic [ROOT_W-1:0] y;     // root bits settled so far
    logic [SQ_W-1:0]   sq;    // y squared
    logic [BITS_W-1:0] bits;  // radicand groups not yet consumed, next group on top
  } stage_t;

endpackage

// ----- design/cbrt_cell.sv -----
// One cell of the cube root chain: brings down a 3-bit group and settles one root bit.
// Depends on cbrt_pkg.
module cbrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  cbrt_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output cbrt_pkg::stage_t dn_data
);
  import cbrt_pkg::*;

  logic            valid_r;
  stage_t          data_r;
  stage_t          data_nxt;
  logic [TRIAL_W-1:0] rem_t;
  logic [TRIAL_W-1:0] b;
  logic [SQ_W+1:0]    sq4;
  logic               take;

  // With y doubled to 2y, the trial subtrahend 3(2y)(2y+1)+1 equals 12*y^2 + 6*y + 1,
  // and a set bit moves y^2 to 4*y^2 + 4*y + 1, so no multiplier is needed.
  always_comb begin
    rem_t = {up_data.rem, up_data.bits[BITS_W-1 -: 3]};
    sq4   = {up_data.sq, 2'b00};
    b     = TRIAL_W'({sq4, 1'b0}) + TRIAL_W'(sq4)
          + TRIAL_W'({up_data.y, 2'b00}) + TRIAL_W'({up_data.y, 1'b0})
          + TRIAL_W'(1);
    take  = (rem_t >= b);

    data_nxt.bits = {up_data.bits[BITS_W-4:0], 3'b000};
    if (take) begin
      data_nxt.rem = REM_W'(rem_t - b);
      data_nxt.y   = {up_data.y[ROOT_W-2:0], 1'b1};
      data_nxt.sq  = SQ_W'(sq4 + {up_data.y, 2'b00} + (SQ_W+2)'(1));
    end else begin
      data_nxt.rem = REM_W'(rem_t);
      data_nxt.y   = {up_data.y[ROOT_W-2:0], 1'b0};
      data_nxt.sq  = SQ_W'(sq4);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- design/integer_cube_root.sv -----
// Integer cube root: floor of the cube root of an unsigned 64-bit radicand.
// Each input transaction passes through every cbrt_cell register in turn before out_tvalid.
// Throughput is one transaction per cycle while out_tready stays high; the chain of 22 registered cells sets it.
// A stalled output holds its cell; empty cells further up keep taking transactions.
// Synchronous active-low reset clears all cell valid flags; data registers are not reset.
// Depends on cbrt_pkg and cbrt_cell.
module integer_cube_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] radicand
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [21:0] root, [23:22] zero
);
  import cbrt_pkg::*;

  logic   link_valid [NUM_CELLS+1];
  logic   link_ready [NUM_CELLS+1];
  stage_t link_data  [NUM_CELLS+1];

  always_comb begin
    link_data[0].rem  = '0;
    link_data[0].y    = '0;
    link_data[0].sq   = '0;
    link_data[0].bits = BITS_W'(in_tdata & RAD_MASK);
  end

  assign link_valid[0] = in_tvalid;
  assign in_tready     = link_ready[0];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    cbrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_data  (link_data[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_data  (link_data[k+1])
    );
  end

  assign out_tvalid           = link_valid[NUM_CELLS];
  assign link_ready[NUM_CELLS] = out_tready;
  assign out_tdata = {(OUT_TDATA_W - ROOT_W)'(0), link_data[NUM_CELLS].y};

endmodule
